FILE: rtl/core/lcdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LCD mode timing block.
// No dependencies; imported by lcdt_regs, lcdt_timing and the top level.
package lcdt_pkg;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_ACK   = 2'd3;

   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_DRAW   = 2'd3;

   localparam logic [3:0] OFS_LCDC = 4'd0;
   localparam logic [3:0] OFS_STAT = 4'd1;
   localparam logic [3:0] OFS_SCY  = 4'd2;
   localparam logic [3:0] OFS_SCX  = 4'd3;
   localparam logic [3:0] OFS_LY   = 4'd4;
   localparam logic [3:0] OFS_LYC  = 4'd5;
   localparam logic [3:0] OFS_DMA  = 4'd6;
   localparam logic [3:0] OFS_BGP  = 4'd7;
   localparam logic [3:0] OFS_OBP0 = 4'd8;
   localparam logic [3:0] OFS_OBP1 = 4'd9;
   localparam logic [3:0] OFS_WY   = 4'd10;
   localparam logic [3:0] OFS_WX   = 4'd11;

   // STAT interrupt enable bits
   localparam int STAT_EN_LYC    = 6;
   localparam int STAT_EN_OAM    = 5;
   localparam int STAT_EN_VBLANK = 4;
   localparam int STAT_EN_HBLANK = 3;

   localparam logic [7:0] VBLANK_FIRST_LINE = 8'd144;
   localparam logic [7:0] LINES_PER_FRAME   = 8'd154;

   localparam int unsigned HBLANK_CYCLES_DEF      = 204;
   localparam int unsigned VBLANK_LINE_CYCLES_DEF = 456;
   localparam int unsigned OAM_CYCLES_DEF         = 80;
   localparam int unsigned DRAW_CYCLES_DEF        = 172;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] line;
      logic       vblank_irq;
      logic       stat_irq;
      logic       frame_ready;
   } timing_status_type;

endpackage

FILE: rtl/core/lcdt_regs.sv
`timescale 1ns / 1ps
// Bus-visible register file: lcdc, stat, lyc and the plain scroll/palette/window bytes.
// Depends on lcdt_pkg.
module lcdt_regs (
   input  logic       clock,
   input  logic       reset,
   input  logic       rd_en,
   input  logic       wr_en,
   input  logic [3:0] offset,
   input  logic [7:0] wdata,
   input  logic [7:0] line,
   output logic [7:0] rdata,
   output logic [7:0] stat,
   output logic [7:0] lyc
);
   import lcdt_pkg::*;

   logic [7:0] control_ff;
   logic [7:0] status_ff;
   logic [7:0] lyc_ff;
   logic [7:0] plain_ff [8];
   logic [2:0] slot;

   // scy/scx map to 0..1, dma..wx map to 2..7
   assign slot = (offset == OFS_SCY || offset == OFS_SCX) ? 3'(offset - OFS_SCY)
                                                          : 3'(offset - OFS_LY);

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         status_ff  <= '0;
         lyc_ff     <= '0;
         for (int i = 0; i < 8; i++) plain_ff[i] <= '0;
      end else if (wr_en) begin
         unique case (offset)
            OFS_LCDC: control_ff <= wdata;
            OFS_STAT: status_ff  <= wdata;
            OFS_LYC:  lyc_ff     <= wdata;
            OFS_SCY, OFS_SCX, OFS_BGP, OFS_OBP0, OFS_OBP1, OFS_WY, OFS_WX: begin
               plain_ff[slot] <= wdata;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rdata = '0;
      if (rd_en) begin
         unique case (offset)
            OFS_LCDC: rdata = control_ff;
            OFS_STAT: rdata = status_ff;
            OFS_LY:   rdata = line;
            OFS_LYC:  rdata = lyc_ff;
            OFS_SCY, OFS_SCX, OFS_DMA, OFS_BGP, OFS_OBP0, OFS_OBP1, OFS_WY, OFS_WX: begin
               rdata = plain_ff[slot];
            end
            default: rdata = '0;
         endcase
      end
   end

   assign stat = status_ff;
   assign lyc  = lyc_ff;

endmodule

FILE: rtl/core/lcdt_timing.sv
`timescale 1ns / 1ps
// Mode sequencer: cycle accumulator, mode, line, coincidence, STAT edge and frame flag.
// Depends on lcdt_pkg.
module lcdt_timing #(
   parameter int unsigned HBLANK_CYCLES      = lcdt_pkg::HBLANK_CYCLES_DEF,
   parameter int unsigned VBLANK_LINE_CYCLES = lcdt_pkg::VBLANK_LINE_CYCLES_DEF,
   parameter int unsigned OAM_CYCLES         = lcdt_pkg::OAM_CYCLES_DEF,
   parameter int unsigned DRAW_CYCLES        = lcdt_pkg::DRAW_CYCLES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick_en,
   input  logic                        ack_en,
   input  logic [7:0]                  cycles,
   input  logic [7:0]                  stat,
   input  logic [7:0]                  lyc,
   output lcdt_pkg::timing_status_type status
);
   import lcdt_pkg::*;

   localparam logic [15:0] HB_THR  = 16'(HBLANK_CYCLES);
   localparam logic [15:0] VB_THR  = 16'(VBLANK_LINE_CYCLES);
   localparam logic [15:0] OAM_THR = 16'(OAM_CYCLES);
   localparam logic [15:0] DRW_THR = 16'(DRAW_CYCLES);

   logic [15:0] accum_ff, accum_in;
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  line_ff, line_in;
   logic        coin_ff, coin_in;
   logic        prev_ff, prev_in;
   logic        ready_ff, ready_in;
   logic [16:0] sum;
   logic [15:0] sat;
   logic [7:0]  line_inc;
   logic        cond;
   logic        virq;
   logic        sirq;

   always_comb begin
      sum      = {1'b0, accum_ff} + {9'b0, cycles};
      sat      = sum[16] ? 16'hFFFF : sum[15:0];
      line_inc = line_ff + 8'd1;
      accum_in = accum_ff;
      mode_in  = mode_ff;
      line_in  = line_ff;
      coin_in  = coin_ff;
      prev_in  = prev_ff;
      ready_in = ready_ff;
      virq     = 1'b0;
      sirq     = 1'b0;
      cond     = 1'b0;
      if (tick_en) begin
         accum_in = sat;
         case (mode_ff)
            MODE_HBLANK: begin
               if (sat >= HB_THR) begin
                  accum_in = sat - HB_THR;
                  line_in  = line_inc;
                  if (line_inc < VBLANK_FIRST_LINE) begin
                     mode_in = MODE_OAM;
                  end else begin
                     mode_in = MODE_VBLANK;
                     virq    = 1'b1;
                  end
               end
            end
            MODE_VBLANK: begin
               if (sat >= VB_THR) begin
                  accum_in = sat - VB_THR;
                  line_in  = line_inc;
                  if (line_inc >= LINES_PER_FRAME) begin
                     line_in  = '0;
                     mode_in  = MODE_OAM;
                     ready_in = 1'b1;
                  end
               end
            end
            MODE_OAM: begin
               if (sat >= OAM_THR) begin
                  accum_in = sat - OAM_THR;
                  coin_in  = (lyc == line_ff);
                  mode_in  = MODE_DRAW;
               end
            end
            default: begin
               if (sat >= DRW_THR) begin
                  accum_in = sat - DRW_THR;
                  mode_in  = MODE_HBLANK;
               end
            end
         endcase
         cond = (stat[STAT_EN_LYC] && coin_in)
             || (stat[STAT_EN_OAM] && mode_in == MODE_OAM)
             || (stat[STAT_EN_VBLANK] && mode_in == MODE_VBLANK)
             || (stat[STAT_EN_HBLANK] && mode_in == MODE_HBLANK);
         sirq    = cond && !prev_ff;
         prev_in = cond;
      end else if (ack_en) begin
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         mode_ff  <= MODE_OAM;
         line_ff  <= '0;
         coin_ff  <= 1'b0;
         prev_ff  <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         accum_ff <= accum_in;
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         coin_ff  <= coin_in;
         prev_ff  <= prev_in;
         ready_ff <= ready_in;
      end
   end

   assign status.mode        = mode_in;
   assign status.line        = line_in;
   assign status.vblank_irq  = virq;
   assign status.stat_irq    = sirq;
   assign status.frame_ready = ready_in;

endmodule

FILE: rtl/core/lcd_mode_timing_with_registers.sv
`timescale 1ns / 1ps
// Top level of the LCD mode timing block: input register, execute, result register.
// Depends on lcdt_pkg, lcdt_regs and lcdt_timing.
//
//   channel | ports                                          | direction
//   req     | req_valid req_stall req_func req_cycles         | in
//           | req_reg_offset req_write_value                  |
//   rsp     | rsp_valid rsp_stall rsp_read_value rsp_lcd_mode | out
//           | rsp_line_number rsp_vblank_irq rsp_stat_irq     |
//           | rsp_frame_ready                                 |
//
// One transaction per cycle sustained while rsp_stall is low; each passes the
// input register, then execute into the result register. Synchronous reset puts
// the sequencer in OAM search on line 0, clears the register file and valid flags.
// A stalled result holds; the input register still takes one more transaction,
// and req_stall rises only when both stages are full and rsp_stall is high.
module lcd_mode_timing_with_registers #(
   parameter int unsigned HBLANK_CYCLES      = lcdt_pkg::HBLANK_CYCLES_DEF,
   parameter int unsigned VBLANK_LINE_CYCLES = lcdt_pkg::VBLANK_LINE_CYCLES_DEF,
   parameter int unsigned OAM_CYCLES         = lcdt_pkg::OAM_CYCLES_DEF,
   parameter int unsigned DRAW_CYCLES        = lcdt_pkg::DRAW_CYCLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_cycles,
   input  logic [3:0] req_reg_offset,
   input  logic [7:0] req_write_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_value,
   output logic [1:0] rsp_lcd_mode,
   output logic [7:0] rsp_line_number,
   output logic       rsp_vblank_irq,
   output logic       rsp_stat_irq,
   output logic       rsp_frame_ready
);
   import lcdt_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_func_ff;
   logic [7:0]        s1_cycles_ff;
   logic [3:0]        s1_offset_ff;
   logic [7:0]        s1_wdata_ff;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        rd_ff;
   timing_status_type tstat_ff;
   logic              advance;
   logic              req_take;
   logic [7:0]        rdata;
   logic [7:0]        stat;
   logic [7:0]        lyc;
   timing_status_type tstat;

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   lcdt_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (advance && s1_func_ff == FUNC_READ),
      .wr_en  (advance && s1_func_ff == FUNC_WRITE),
      .offset (s1_offset_ff),
      .wdata  (s1_wdata_ff),
      .line   (tstat.line),
      .rdata  (rdata),
      .stat   (stat),
      .lyc    (lyc)
   );

   lcdt_timing #(
      .HBLANK_CYCLES      (HBLANK_CYCLES),
      .VBLANK_LINE_CYCLES (VBLANK_LINE_CYCLES),
      .OAM_CYCLES         (OAM_CYCLES),
      .DRAW_CYCLES        (DRAW_CYCLES)
   ) u_timing (
      .clock   (clock),
      .reset   (reset),
      .tick_en (advance && s1_func_ff == FUNC_TICK),
      .ack_en  (advance && s1_func_ff == FUNC_ACK),
      .cycles  (s1_cycles_ff),
      .stat    (stat),
      .lyc     (lyc),
      .status  (tstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         s1_func_ff   <= req_func;
         s1_cycles_ff <= req_cycles;
         s1_offset_ff <= req_reg_offset;
         s1_wdata_ff  <= req_write_value;
      end
      if (advance) begin
         rd_ff    <= rdata;
         tstat_ff <= tstat;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_lcd_mode    = tstat_ff.mode;
   assign rsp_line_number = tstat_ff.line;
   assign rsp_vblank_irq  = tstat_ff.vblank_irq;
   assign rsp_stat_irq    = tstat_ff.stat_irq;
   assign rsp_frame_ready = tstat_ff.frame_ready;

`ifndef SYNTHESIS
   a_vblank_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vblank_irq |->
         rsp_lcd_mode == MODE_VBLANK && rsp_line_number == VBLANK_FIRST_LINE)
      else $error("vblank irq outside vblank entry");

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number < LINES_PER_FRAME)
      else $error("line number out of range");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff)
      else $error("input stalled with a free stage");

   a_wrap_ready: assert property (@(posedge clock) disable iff (reset)
      advance && tstat.line == 8'd0 && tstat_ff.line != 8'd0 && out_valid_ff
         |-> tstat.frame_ready)
      else $error("frame wrap without frame ready");
`endif

endmodule
